// ----- rtl/ddw_pkg.sv -----
// ----------------------------------------------------------------------------
// ddw_pkg: shared types, constants and month tables
// Field widths, year limits and the per-month tables used by the calendar
// decoder and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ddw_pkg;

    // Field widths
    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WEEKDAY_W = 3;
    localparam int DAYNUM_W  = 16;

    // Offset of the year from the first supported year, 0..199
    localparam int YOFF_W    = 8;
    // Days counted from 1900-01-01, up to 73048
    localparam int DCOUNT_W  = 17;
    // Days before the first of a month, up to 334
    localparam int DBM_W     = 9;

    localparam logic [YEAR_W-1:0]   YearMin   = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]   YearMax   = YEAR_W'(2099);
    localparam logic [YEAR_W-1:0]   YearEpoch = YEAR_W'(1970);
    localparam logic [MONTH_W-1:0]  MonthFeb  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0]  MonthMax  = MONTH_W'(12);
    // Day count of 1970-01-01 measured from 1900-01-01
    localparam logic [DCOUNT_W-1:0] EpochDays = DCOUNT_W'(25567);

    typedef struct packed {
        logic [YEAR_W-1:0]  year_in;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
    } date_t;

    typedef struct packed {
        logic                 date_valid;
        logic                 leap_flag;
        logic [WEEKDAY_W-1:0] weekday;
        logic                 epoch_range;
        logic [DAYNUM_W-1:0]  day_number;
    } result_t;

    // Days before the first of the month in a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Same table reduced modulo 7, for the weekday sum
    function automatic logic [WEEKDAY_W-1:0] month_wd_offset(input logic [MONTH_W-1:0] m);
        logic [WEEKDAY_W-1:0] r;
        unique case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Month length in a common year
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ddw_if.sv -----
// ----------------------------------------------------------------------------
// ddw_if: request and result channels of the calendar decoder
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddw_date_if;
    logic                          valid;
    logic                          ready;
    logic [ddw_pkg::YEAR_W-1:0]    year_in;
    logic [ddw_pkg::MONTH_W-1:0]   month_in;
    logic [ddw_pkg::DAY_W-1:0]     day_in;

    modport source (output valid, output year_in, output month_in, output day_in,
                    input ready);
    modport sink   (input valid, input year_in, input month_in, input day_in,
                    output ready);
endinterface

interface ddw_result_if;
    logic                          valid;
    logic                          ready;
    logic                          date_valid;
    logic                          leap_flag;
    logic [ddw_pkg::WEEKDAY_W-1:0] weekday;
    logic                          epoch_range;
    logic [ddw_pkg::DAYNUM_W-1:0]  day_number;

    modport source (output valid, output date_valid, output leap_flag, output weekday,
                    output epoch_range, output day_number, input ready);
    modport sink   (input valid, input date_valid, input leap_flag, input weekday,
                    input epoch_range, input day_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/ddw_calc.sv -----
// ----------------------------------------------------------------------------
// ddw_calc: date check, leap year, weekday and day number
// Combinational decode of one registered date into one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_calc (
    input  wire ddw_pkg::date_t date,
    output ddw_pkg::result_t    result
);

    logic [ddw_pkg::YOFF_W-1:0]    yoff;
    logic [5:0]                    leaps_before;
    logic                          leap;
    logic [ddw_pkg::DAY_W-1:0]     mlen;
    logic                          valid;
    logic                          past_feb_leap;
    logic [ddw_pkg::DCOUNT_W-1:0]  dcount;
    logic [ddw_pkg::DCOUNT_W-1:0]  dnum_full;
    logic [8:0]                    wd_sum;
    logic [4:0]                    wd_fold1;
    logic [3:0]                    wd_fold2;
    logic [ddw_pkg::WEEKDAY_W-1:0] wd;

    // Year offset from 1900; only meaningful inside the supported range
    assign yoff = ddw_pkg::YOFF_W'(date.year_in - ddw_pkg::YearMin);

    // Leap years in 1900..2099: divisible by four, except 1900
    assign leap = (date.year_in[1:0] == 2'b00) && (date.year_in != ddw_pkg::YearMin);

    // Leap days in the years before this one, counted from 1900
    assign leaps_before = 6'((9'(yoff) + 9'd3) >> 2) - 6'(yoff != '0);

    // Month length with the February fixup
    always_comb
    begin
        mlen = ddw_pkg::month_length(date.month_in);
        if ((date.month_in == ddw_pkg::MonthFeb) && leap)
            mlen = 5'd29;
    end

    // Range check of all three fields
    assign valid = (date.year_in >= ddw_pkg::YearMin) && (date.year_in <= ddw_pkg::YearMax)
                && (date.month_in != '0) && (date.month_in <= ddw_pkg::MonthMax)
                && (date.day_in != '0) && (date.day_in <= mlen);

    assign past_feb_leap = leap && (date.month_in > ddw_pkg::MonthFeb);

    // Days since 1900-01-01
    assign dcount = ddw_pkg::DCOUNT_W'(yoff) * ddw_pkg::DCOUNT_W'(365)
                  + ddw_pkg::DCOUNT_W'(leaps_before)
                  + ddw_pkg::DCOUNT_W'(ddw_pkg::days_before_month(date.month_in))
                  + ddw_pkg::DCOUNT_W'(past_feb_leap)
                  + ddw_pkg::DCOUNT_W'(date.day_in)
                  - ddw_pkg::DCOUNT_W'(1);

    assign dnum_full = dcount - ddw_pkg::EpochDays;

    // Weekday: 1900-01-01 is a Monday and 365 is 1 mod 7, so the sum
    // below equals (day count + 1) mod 7 once reduced
    assign wd_sum = 9'(yoff) + 9'(leaps_before)
                  + 9'(ddw_pkg::month_wd_offset(date.month_in))
                  + 9'(past_feb_leap) + 9'(date.day_in);

    // Reduce mod 7 by folding octal digits (8 is 1 mod 7)
    assign wd_fold1 = 5'(wd_sum[8:6]) + 5'(wd_sum[5:3]) + 5'(wd_sum[2:0]);
    assign wd_fold2 = 4'(wd_fold1[4:3]) + 4'(wd_fold1[2:0]);
    assign wd       = (wd_fold2 >= 4'd7) ? 3'(wd_fold2 - 4'd7) : 3'(wd_fold2);

    // Zero everything for an invalid date
    always_comb
    begin
        result.date_valid  = valid;
        result.leap_flag   = valid && leap;
        result.weekday     = valid ? wd : '0;
        result.epoch_range = valid && (date.year_in >= ddw_pkg::YearEpoch);
        result.day_number  = result.epoch_range ? ddw_pkg::DAYNUM_W'(dnum_full) : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/date_decode_day_number_weekday_core.sv -----
// ----------------------------------------------------------------------------
// date_decode_day_number_weekday_core: calendar date decoder
// Checks a Gregorian date and gives leap flag, weekday and day number.
// ----------------------------------------------------------------------------
//
//   Port     Role     Payload
//   date     sink     year_in, month_in, day_in
//   result   source   date_valid, leap_flag, weekday, epoch_range, day_number
//
// Two register stages: the request register, then the result register after
// the decode logic. One request is taken every cycle while results drain.
// A stall on result holds both stages; date.ready falls only when both are
// full. rst_n clears the valid flags; payload registers are not reset.
//
`default_nettype none

module date_decode_day_number_weekday_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ddw_date_if.sink    date,
    ddw_result_if.source result
);

    logic               req_valid_reg;
    logic               req_valid_next;
    ddw_pkg::date_t     req_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    ddw_pkg::result_t   rsp_reg;
    ddw_pkg::result_t   rsp_next;
    logic               req_take;
    logic               advance;

    // Handshake: move to the result stage when it is empty or being drained
    assign advance    = req_valid_reg && (!rsp_valid_reg || result.ready);
    assign date.ready = !req_valid_reg || advance;
    assign req_take   = date.valid && date.ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_take)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = 1'b1;
        else if (result.ready)
            rsp_valid_next = 1'b0;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg.year_in  <= date.year_in;
            req_reg.month_in <= date.month_in;
            req_reg.day_in   <= date.day_in;
        end
    end

    // Decode
    ddw_calc u_calc (
        .date   (req_reg),
        .result (rsp_next)
    );

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign result.valid       = rsp_valid_reg;
    assign result.date_valid  = rsp_reg.date_valid;
    assign result.leap_flag   = rsp_reg.leap_flag;
    assign result.weekday     = rsp_reg.weekday;
    assign result.epoch_range = rsp_reg.epoch_range;
    assign result.day_number  = rsp_reg.day_number;

endmodule

`default_nettype wire
